// ----- hdl/fcs_pkg.sv -----
// Shared types, codes and constants for the FPGA configuration supervisor.
package fcs_pkg;

    // Port widths
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int TICK_W      = 32;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PINS_MONITORED = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOAD_TIMEOUT   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DETECT_TIMEOUT = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_HOLD     = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL  = 8'd4;

    // Configuration reset values
    localparam logic [TICK_W-1:0] LOAD_TIMEOUT_RST   = 32'd5000;
    localparam logic [TICK_W-1:0] DETECT_TIMEOUT_RST = 32'd1000;
    localparam logic [TICK_W-1:0] ERROR_HOLD_RST     = 32'd1000;
    localparam logic [TICK_W-1:0] POLL_INTERVAL_RST  = 32'd1000;

    // Presence mark codes
    localparam logic [1:0] MARK_NONE    = 2'd0;
    localparam logic [1:0] MARK_UNKNOWN = 2'd1;
    localparam logic [1:0] MARK_FAILED  = 2'd2;

    // Timeout event codes
    localparam logic [1:0] TMO_NONE   = 2'd0;
    localparam logic [1:0] TMO_LOAD   = 2'd1;
    localparam logic [1:0] TMO_DETECT = 2'd2;

    typedef enum logic [2:0] {
        ST_STANDBY = 3'd0,
        ST_LOAD    = 3'd1,
        ST_RESET   = 3'd2,
        ST_RUN     = 3'd3,
        ST_PAUSE   = 3'd4,
        ST_ERROR   = 3'd5
    } state_t;

    typedef struct packed {
        logic              pins_monitored;
        logic [TICK_W-1:0] load_timeout;
        logic [TICK_W-1:0] detect_timeout;
        logic [TICK_W-1:0] error_hold;
        logic [TICK_W-1:0] poll_interval;
    } cfg_t;

    typedef struct packed {
        logic [TICK_W-1:0] now_tick;
        logic              power_enable;
        logic              core_power_ok;
        logic              init_pin;
        logic              done_pin;
        logic              detect_ok;
        logic              refresh_ok;
    } poll_t;

    typedef struct packed {
        state_t     fsm_state;
        logic [1:0] present_mark;
        logic       detect_used;
        logic       refresh_used;
        logic [1:0] timeout_event;
    } result_t;

endpackage

// ----- hdl/fcs_cfg_regs.sv -----
// Configuration register bank of the FPGA configuration supervisor.
module fcs_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fcs_pkg::cfg_t                  cfg
);
    import fcs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode a write transfer; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PINS_MONITORED: cfg_next.pins_monitored = cfg_data[0];
                REG_LOAD_TIMEOUT:   cfg_next.load_timeout   = cfg_data;
                REG_DETECT_TIMEOUT: cfg_next.detect_timeout = cfg_data;
                REG_ERROR_HOLD:     cfg_next.error_hold     = cfg_data;
                REG_POLL_INTERVAL:  cfg_next.poll_interval  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pins_monitored <= 1'b1;
            cfg_reg.load_timeout   <= LOAD_TIMEOUT_RST;
            cfg_reg.detect_timeout <= DETECT_TIMEOUT_RST;
            cfg_reg.error_hold     <= ERROR_HOLD_RST;
            cfg_reg.poll_interval  <= POLL_INTERVAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/fcs_step_logic.sv -----
// Next-state and flag logic for one poll of the supervisor.
module fcs_step_logic (
    input  fcs_pkg::state_t              state,
    input  logic [fcs_pkg::TICK_W-1:0]   entry_tick,
    input  fcs_pkg::poll_t               poll,
    input  fcs_pkg::cfg_t                cfg,
    output fcs_pkg::result_t             res,
    output logic                         state_chg
);
    import fcs_pkg::*;

    logic              init_lv;
    logic              done_lv;
    logic              power;
    logic              enable;
    logic              done;
    logic [TICK_W-1:0] elapsed;

    // Qualify pins and power
    assign init_lv = cfg.pins_monitored ? poll.init_pin : 1'b1;
    assign done_lv = cfg.pins_monitored ? poll.done_pin : 1'b1;
    assign power   = poll.power_enable & poll.core_power_ok;
    assign enable  = power & init_lv;
    assign done    = power & done_lv;
    assign elapsed = poll.now_tick - entry_tick;

    // Later rules within a state override earlier ones
    always_comb begin
        res.fsm_state     = state;
        res.present_mark  = MARK_NONE;
        res.detect_used   = 1'b0;
        res.refresh_used  = 1'b0;
        res.timeout_event = TMO_NONE;
        unique case (state)
            ST_STANDBY: begin
                res.present_mark = MARK_UNKNOWN;
                if (enable) res.fsm_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (!enable) res.fsm_state = ST_STANDBY;
                if (done) res.fsm_state = ST_RESET;
                if (elapsed > cfg.load_timeout) begin
                    res.fsm_state     = ST_ERROR;
                    res.timeout_event = TMO_LOAD;
                end
            end
            ST_RESET: begin
                res.detect_used = 1'b1;
                if (!power) res.fsm_state = ST_STANDBY;
                if (poll.detect_ok) res.fsm_state = ST_RUN;
                if (elapsed > cfg.detect_timeout) begin
                    res.fsm_state     = ST_ERROR;
                    res.timeout_event = TMO_DETECT;
                end
            end
            ST_RUN: begin
                res.refresh_used = 1'b1;
                res.fsm_state    = poll.refresh_ok ? ST_PAUSE : ST_ERROR;
            end
            ST_PAUSE: begin
                if (!done) res.fsm_state = ST_STANDBY;
                if (elapsed > cfg.poll_interval) res.fsm_state = ST_RUN;
            end
            ST_ERROR: begin
                res.present_mark = MARK_FAILED;
                if (elapsed > cfg.error_hold) res.fsm_state = ST_STANDBY;
            end
            default: res.fsm_state = state;
        endcase
    end

    assign state_chg = (res.fsm_state != state);

endmodule

// ----- hdl/fpga_config_supervisor_fsm_unit.sv -----
// Top level of the FPGA configuration supervisor: poll register, state and result register.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: one poll
//  m_       | out | m_tvalid/m_tready  | m_tdata: one result per poll
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data: register write
//
// A poll passes from the poll register through the step logic into the result
// register. One poll per cycle is sustained while results drain, bounded by
// the single state register update per poll.
// Reset (aresetn low, synchronous) returns the machine to standby with entry
// tick zero and restores the register defaults. A stalled result holds the
// pipeline; the poll register takes a poll while the result waits only if it is empty.
module fpga_config_supervisor_fsm_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] now_tick, [32] power_enable, [33] core_power_ok, [34] init_pin,
    // [35] done_pin, [36] detect_ok, [37] refresh_ok, [39:38] zero
    input  logic [fcs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] fsm_state, [4:3] present_mark, [5] detect_used,
    // [6] refresh_used, [8:7] timeout_event, [15:9] zero
    output logic [fcs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fcs_pkg::*;

    cfg_t              cfg;
    poll_t             s_poll;
    poll_t             poll_reg;
    logic              in_valid_reg;
    state_t            state_reg;
    state_t            state_next;
    logic [TICK_W-1:0] entry_tick_reg;
    logic [TICK_W-1:0] entry_tick_next;
    result_t           res;
    result_t           res_reg;
    logic              m_valid_reg;
    logic              state_chg;
    logic              advance;

    fcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the incoming poll
    assign s_poll.now_tick      = s_tdata[31:0];
    assign s_poll.power_enable  = s_tdata[32];
    assign s_poll.core_power_ok = s_tdata[33];
    assign s_poll.init_pin      = s_tdata[34];
    assign s_poll.done_pin      = s_tdata[35];
    assign s_poll.detect_ok     = s_tdata[36];
    assign s_poll.refresh_ok    = s_tdata[37];

    // Advance when a poll is held and the result slot is free or drains
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    fcs_step_logic u_step (
        .state      (state_reg),
        .entry_tick (entry_tick_reg),
        .poll       (poll_reg),
        .cfg        (cfg),
        .res        (res),
        .state_chg  (state_chg)
    );

    assign state_next      = advance ? res.fsm_state : state_reg;
    assign entry_tick_next = (advance && state_chg) ? poll_reg.now_tick : entry_tick_reg;

    // Poll register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            poll_reg <= s_poll;
        end
    end

    // Machine state and entry tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_STANDBY;
            entry_tick_reg <= '0;
        end else begin
            state_reg      <= state_next;
            entry_tick_reg <= entry_tick_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, res_reg.timeout_event, res_reg.refresh_used,
                       res_reg.detect_used, res_reg.present_mark, res_reg.fsm_state};

`ifndef NO_ASSERTIONS
    // A pending result always reports the state the machine now holds
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (res_reg.fsm_state == state_reg))
        else $error("pending result state differs from machine state");

    // A timeout always lands in error
    a_timeout_to_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (res_reg.timeout_event != TMO_NONE))
            |-> (res_reg.fsm_state == ST_ERROR))
        else $error("timeout reported outside error state");

    // Detect and refresh outcomes are never consumed in the same poll
    a_single_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(res_reg.detect_used && res_reg.refresh_used))
        else $error("detect and refresh consumed together");

    // A state change records the poll tick as the entry tick
    a_entry_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && state_chg) |=> (entry_tick_reg == $past(poll_reg.now_tick)))
        else $error("entry tick not taken on state change");
`endif

endmodule
